// ----- hdl/i2cs_pkg.sv -----
package i2cs_pkg;

	localparam int ADDR_W    = 16;
	localparam int CNT_W     = 16;
	localparam int POLL_W    = 16;
	localparam int RES_MAX   = 4;
	localparam int RES_CNT_W = $clog2(RES_MAX + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// request codes; 5..7 are meaningless and ignored
	localparam logic [2:0] REQ_BEGIN_READ  = 3'd0;
	localparam logic [2:0] REQ_BEGIN_WRITE = 3'd1;
	localparam logic [2:0] REQ_WRITE_DATA  = 3'd2;
	localparam logic [2:0] REQ_ACK         = 3'd3;
	localparam logic [2:0] REQ_READ_BYTE   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_CONTROL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TWO_ADDR       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BITS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT     = 3'd4;

	localparam logic [7:0]        RST_DEVICE_CONTROL = 8'hA0;
	localparam logic              RST_TWO_ADDR       = 1'b0;
	localparam logic              RST_HIGH_BITS      = 1'b1;
	localparam logic [3:0]        RST_PAGE_LOG2      = 4'd4;
	localparam logic [POLL_W-1:0] RST_POLL_LIMIT     = 16'd1000;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_STOP    = 3'd1,
		OP_SEND    = 3'd2,
		OP_WAIT    = 3'd3,
		OP_RD_ACK  = 3'd4,
		OP_RD_NACK = 3'd5,
		OP_STATUS  = 3'd6
	} bus_op_t;

	typedef enum logic [1:0] {
		ST_BUSY    = 2'd0,
		ST_OK      = 2'd1,
		ST_NACK    = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_CTRL_ACK   = 4'd1,
		PH_ADDRH_ACK  = 4'd2,
		PH_ADDRL_ACK  = 4'd3,
		PH_RCTRL_ACK  = 4'd4,
		PH_RDATA      = 4'd5,
		PH_WDATA_WAIT = 4'd6,
		PH_WDATA_ACK  = 4'd7,
		PH_FINAL_POLL = 4'd8
	} phase_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [ADDR_W-1:0] address;
		logic [CNT_W-1:0]  count;
		logic [7:0]        write_byte;
		logic              nack;
		logic [7:0]        bus_read_byte;
	} item_t;

	typedef struct packed {
		bus_op_t    bus_op;
		logic [7:0] bus_byte;
		logic [7:0] read_data;
		logic       read_valid;
		logic       want_data;
		status_t    status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [7:0]        dev_ctrl;
		logic              two_addr;
		logic              high_bits;
		logic [3:0]        page_log2;
		logic [POLL_W-1:0] poll_limit;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic              is_write;
		logic [ADDR_W-1:0] cur_addr;
		logic [CNT_W-1:0]  bytes_left;
		logic [POLL_W-1:0] poll_count;
	} state_t;

	function automatic res_t mk_res(bus_op_t op, logic [7:0] b, logic [7:0] rd, logic rv,
			logic want, status_t s);
		res_t r;
		r.bus_op     = op;
		r.bus_byte   = b;
		r.read_data  = rd;
		r.read_valid = rv;
		r.want_data  = want;
		r.status     = s;
		r.last       = 1'b0;
		return r;
	endfunction

	// device address with R/W in bit 0, optionally A10..A8 in bits 3..1
	function automatic logic [7:0] ctrl_byte(cfg_t c, logic [ADDR_W-1:0] a, logic rw);
		logic [7:0] v;
		v = {c.dev_ctrl[7:1], rw};
		if (c.high_bits) begin
			v = v | {4'b0000, a[10:8], 1'b0};
		end
		return v;
	endfunction

endpackage

// ----- hdl/i2cs_req_if.sv -----
interface i2cs_req_if;
	import i2cs_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        req_type;
	logic [ADDR_W-1:0] address;
	logic [CNT_W-1:0]  count;
	logic [7:0]        write_byte;
	logic              nack;
	logic [7:0]        bus_read_byte;

	modport source (output valid, req_type, address, count, write_byte, nack, bus_read_byte,
		input ready);
	modport sink (input valid, req_type, address, count, write_byte, nack, bus_read_byte,
		output ready);
endinterface

// ----- hdl/i2cs_res_if.sv -----
interface i2cs_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] bus_op;
	logic [7:0] bus_byte;
	logic [7:0] read_data;
	logic       read_valid;
	logic       want_data;
	logic [1:0] status;
	logic       last;

	modport source (output valid, bus_op, bus_byte, read_data, read_valid, want_data, status,
		last, input ready);
	modport sink (input valid, bus_op, bus_byte, read_data, read_valid, want_data, status,
		last, output ready);
endinterface

// ----- hdl/i2cs_cfg_if.sv -----
interface i2cs_cfg_if;
	import i2cs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/i2cs_step.sv -----
module i2cs_step
	import i2cs_pkg::*;
(
	input  state_t                   st,
	input  cfg_t                     cfg,
	input  item_t                    item,
	output state_t                   st_nxt,
	output res_t [RES_MAX-1:0]       res,
	output logic [RES_CNT_W-1:0]     res_n
);

	logic [ADDR_W-1:0] addr_inc;
	logic [CNT_W-1:0]  left_dec;
	logic [ADDR_W-1:0] page_mask;
	logic [POLL_W-1:0] poll_lim;
	logic              is_ack;
	logic              poll_timeout;
	logic [7:0]        ctrl_cur_w;

	assign addr_inc     = st.cur_addr + 1'b1;
	assign left_dec     = st.bytes_left - 1'b1;
	assign page_mask    = (ADDR_W'(1) << cfg.page_log2) - 1'b1;
	assign poll_lim     = (cfg.poll_limit == '0) ? POLL_W'(1) : cfg.poll_limit;
	assign is_ack       = (item.req_type == REQ_ACK);
	assign poll_timeout = (st.poll_count >= poll_lim);
	assign ctrl_cur_w   = ctrl_byte(cfg, st.cur_addr, 1'b0);

	always_comb begin
		st_nxt = st;
		res    = '0;
		res_n  = '0;

		case (st.phase)
			PH_IDLE: begin
				if (item.req_type == REQ_BEGIN_READ) begin
					st_nxt.cur_addr   = item.address;
					st_nxt.bytes_left = item.count;
					st_nxt.is_write   = 1'b0;
					res[0] = mk_res(OP_START, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
					res[1] = mk_res(OP_SEND, ctrl_byte(cfg, item.address, 1'b0), 8'd0, 1'b0,
						1'b0, ST_BUSY);
					res[2] = mk_res(OP_WAIT, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
					res_n  = RES_CNT_W'(3);
					st_nxt.phase = PH_CTRL_ACK;
				end else if (item.req_type == REQ_BEGIN_WRITE) begin
					st_nxt.cur_addr   = item.address;
					st_nxt.bytes_left = item.count;
					st_nxt.is_write   = 1'b1;
					st_nxt.poll_count = POLL_W'(1);
					res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
					res[1] = mk_res(OP_START, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
					res[2] = mk_res(OP_SEND, ctrl_byte(cfg, item.address, 1'b0), 8'd0, 1'b0,
						1'b0, ST_BUSY);
					res[3] = mk_res(OP_WAIT, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
					res_n  = RES_CNT_W'(4);
					st_nxt.phase = (item.count == '0) ? PH_FINAL_POLL : PH_CTRL_ACK;
				end
			end
			PH_CTRL_ACK, PH_FINAL_POLL: begin
				if (is_ack) begin
					if (item.nack && (st.is_write || st.phase == PH_FINAL_POLL)) begin
						// device still busy with its internal write: poll again, or stop with a timeout once the poll limit is reached
						if (poll_timeout) begin
							res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, ST_TIMEOUT);
							res_n  = RES_CNT_W'(1);
							st_nxt.phase = PH_IDLE;
						end else begin
							st_nxt.poll_count = st.poll_count + 1'b1;
							res[0] = mk_res(OP_START, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
							res[1] = mk_res(OP_SEND, ctrl_cur_w, 8'd0, 1'b0, 1'b0, ST_BUSY);
							res[2] = mk_res(OP_WAIT, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
							res_n  = RES_CNT_W'(3);
						end
					end else if (item.nack) begin
						res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, ST_NACK);
						res_n  = RES_CNT_W'(1);
						st_nxt.phase = PH_IDLE;
					end else if (st.phase == PH_FINAL_POLL) begin
						res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, ST_OK);
						res_n  = RES_CNT_W'(1);
						st_nxt.phase = PH_IDLE;
					end else begin
						if (cfg.two_addr) begin
							res[0] = mk_res(OP_SEND, st.cur_addr[15:8], 8'd0, 1'b0, 1'b0,
								ST_BUSY);
							st_nxt.phase = PH_ADDRH_ACK;
						end else begin
							res[0] = mk_res(OP_SEND, st.cur_addr[7:0], 8'd0, 1'b0, 1'b0,
								ST_BUSY);
							st_nxt.phase = PH_ADDRL_ACK;
						end
						res[1] = mk_res(OP_WAIT, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
						res_n  = RES_CNT_W'(2);
					end
				end
			end
			PH_ADDRH_ACK, PH_ADDRL_ACK, PH_RCTRL_ACK, PH_WDATA_ACK: begin
				if (is_ack) begin
					if (item.nack) begin
						res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, ST_NACK);
						res_n  = RES_CNT_W'(1);
						st_nxt.phase = PH_IDLE;
					end else if (st.phase == PH_ADDRH_ACK) begin
						res[0] = mk_res(OP_SEND, st.cur_addr[7:0], 8'd0, 1'b0, 1'b0, ST_BUSY);
						res[1] = mk_res(OP_WAIT, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
						res_n  = RES_CNT_W'(2);
						st_nxt.phase = PH_ADDRL_ACK;
					end else if (st.phase == PH_ADDRL_ACK) begin
						if (st.is_write) begin
							res[0] = mk_res(OP_STATUS, 8'd0, 8'd0, 1'b0, 1'b1, ST_BUSY);
							res_n  = RES_CNT_W'(1);
							st_nxt.phase = PH_WDATA_WAIT;
						end else begin
							// repeated start with the read control byte
							res[0] = mk_res(OP_START, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
							res[1] = mk_res(OP_SEND, ctrl_byte(cfg, st.cur_addr, 1'b1), 8'd0,
								1'b0, 1'b0, ST_BUSY);
							res[2] = mk_res(OP_WAIT, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
							res_n  = RES_CNT_W'(3);
							st_nxt.phase = PH_RCTRL_ACK;
						end
					end else if (st.phase == PH_RCTRL_ACK) begin
						if (st.bytes_left == '0) begin
							res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, ST_OK);
							st_nxt.phase = PH_IDLE;
						end else begin
							res[0] = mk_res((st.bytes_left == CNT_W'(1)) ? OP_RD_NACK : OP_RD_ACK,
								8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
							st_nxt.phase = PH_RDATA;
						end
						res_n = RES_CNT_W'(1);
					end else begin
						st_nxt.cur_addr   = addr_inc;
						st_nxt.bytes_left = left_dec;
						if (left_dec == '0 || (addr_inc & page_mask) == '0) begin
							// end of transfer or page boundary: stop and poll
							st_nxt.poll_count = POLL_W'(1);
							res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
							res[1] = mk_res(OP_START, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
							res[2] = mk_res(OP_SEND, ctrl_byte(cfg, addr_inc, 1'b0), 8'd0, 1'b0,
								1'b0, ST_BUSY);
							res[3] = mk_res(OP_WAIT, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
							res_n  = RES_CNT_W'(4);
							st_nxt.phase = (left_dec == '0) ? PH_FINAL_POLL : PH_CTRL_ACK;
						end else begin
							res[0] = mk_res(OP_STATUS, 8'd0, 8'd0, 1'b0, 1'b1, ST_BUSY);
							res_n  = RES_CNT_W'(1);
							st_nxt.phase = PH_WDATA_WAIT;
						end
					end
				end
			end
			PH_RDATA: begin
				if (item.req_type == REQ_READ_BYTE) begin
					st_nxt.bytes_left = left_dec;
					if (left_dec == '0) begin
						res[0] = mk_res(OP_STOP, 8'd0, item.bus_read_byte, 1'b1, 1'b0, ST_OK);
						st_nxt.phase = PH_IDLE;
					end else begin
						res[0] = mk_res((left_dec == CNT_W'(1)) ? OP_RD_NACK : OP_RD_ACK, 8'd0,
							item.bus_read_byte, 1'b1, 1'b0, ST_BUSY);
					end
					res_n = RES_CNT_W'(1);
				end
			end
			PH_WDATA_WAIT: begin
				if (item.req_type == REQ_WRITE_DATA) begin
					res[0] = mk_res(OP_SEND, item.write_byte, 8'd0, 1'b0, 1'b0, ST_BUSY);
					res[1] = mk_res(OP_WAIT, 8'd0, 8'd0, 1'b0, 1'b0, ST_BUSY);
					res_n  = RES_CNT_W'(2);
					st_nxt.phase = PH_WDATA_ACK;
				end
			end
			default: begin
			end
		endcase

		for (int i = 0; i < RES_MAX; i++) begin
			res[i].last = (RES_CNT_W'(i + 1) == res_n);
		end
	end

endmodule

// ----- hdl/i2c_eeprom_transfer_sequencer_core.sv -----
// channel | dir | transaction
// req     | in  | one request or bus response (req_type, address, count, write_byte, nack,
//         |     | bus_read_byte)
// res     | out | one bus primitive with read data, want_data, status and last
// cfg     | in  | one register write (index, data); always ready
//
// An accepted request waits in the input register until the buffer can take it; then
// its 0..4 results are loaded into a four-entry result buffer and go out one per cycle
// while the output is ready. The next request is taken while results still drain; the
// buffer reloads on the cycle its last entry leaves. Output stalls hold the buffer and,
// once the input register is full, the input. Reset clears the sequencer state and
// restores the register defaults.
module i2c_eeprom_transfer_sequencer_core
	import i2cs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	i2cs_req_if.sink   req,
	i2cs_res_if.source res,
	i2cs_cfg_if.sink   cfg
);

	cfg_t                     cfg_q;
	state_t                   state_q;
	state_t                   state_nxt;
	item_t                    item_s1;
	logic                     item_vld_s1;
	res_t [RES_MAX-1:0]       buf_q;
	logic [RES_CNT_W-1:0]     cnt_q;
	res_t [RES_MAX-1:0]       step_res;
	logic [RES_CNT_W-1:0]     step_n;
	logic                     pop;
	logic                     load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_ctrl   <= RST_DEVICE_CONTROL;
			cfg_q.two_addr   <= RST_TWO_ADDR;
			cfg_q.high_bits  <= RST_HIGH_BITS;
			cfg_q.page_log2  <= RST_PAGE_LOG2;
			cfg_q.poll_limit <= RST_POLL_LIMIT;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DEVICE_CONTROL: cfg_q.dev_ctrl   <= cfg.data[7:0];
				CFG_TWO_ADDR:       cfg_q.two_addr   <= cfg.data[0];
				CFG_HIGH_BITS:      cfg_q.high_bits  <= cfg.data[0];
				CFG_PAGE_LOG2:      cfg_q.page_log2  <= cfg.data[3:0];
				CFG_POLL_LIMIT:     cfg_q.poll_limit <= cfg.data[POLL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	i2cs_step u_step (
		.st     (state_q),
		.cfg    (cfg_q),
		.item   (item_s1),
		.st_nxt (state_nxt),
		.res    (step_res),
		.res_n  (step_n)
	);

	assign pop       = res.valid && res.ready;
	assign load      = item_vld_s1 && (cnt_q == '0 || (cnt_q == RES_CNT_W'(1) && res.ready));
	assign req.ready = !item_vld_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			item_vld_s1 <= 1'b1;
		end else if (load) begin
			item_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type      <= req.req_type;
			item_s1.address       <= req.address;
			item_s1.count         <= req.count;
			item_s1.write_byte    <= req.write_byte;
			item_s1.nack          <= req.nack;
			item_s1.bus_read_byte <= req.bus_read_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.is_write   <= 1'b0;
			state_q.cur_addr   <= '0;
			state_q.bytes_left <= '0;
			state_q.poll_count <= '0;
			cnt_q              <= '0;
		end else if (load) begin
			state_q <= state_nxt;
			cnt_q   <= step_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// result buffer: head at entry 0, shifts down on each accepted result
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= step_res;
		end else if (pop) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	assign res.valid      = (cnt_q != '0);
	assign res.bus_op     = buf_q[0].bus_op;
	assign res.bus_byte   = buf_q[0].bus_byte;
	assign res.read_data  = buf_q[0].read_data;
	assign res.read_valid = buf_q[0].read_valid;
	assign res.want_data  = buf_q[0].want_data;
	assign res.status     = buf_q[0].status;
	assign res.last       = buf_q[0].last;

endmodule

// ----- hdl/i2cs_checker.sv -----
module i2cs_checker
	import i2cs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_bus_op,
	input logic [7:0] res_bus_byte,
	input logic       res_read_valid,
	input logic       res_want_data,
	input logic [1:0] res_status,
	input logic       res_last
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_bus_op) && $stable(res_status)
			&& $stable(res_bus_byte) && $stable(res_last))
		else $error("result changed while stalled");

	// a final status only rides on the closing stop
	a_status_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_BUSY |-> res_bus_op == OP_STOP && res_last)
		else $error("status on a non-final or non-stop result");

	// delivered bytes come with the next read op or the final stop
	a_read_op: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_read_valid |-> res_bus_op == OP_RD_ACK || res_bus_op == OP_RD_NACK
			|| res_bus_op == OP_STOP)
		else $error("read data on an unexpected bus op");

	a_want_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_want_data |-> res_bus_op == OP_STATUS && res_last)
		else $error("want_data outside a closing status-only result");

	a_byte_send: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_bus_byte != 8'd0 |-> res_bus_op == OP_SEND)
		else $error("bus byte set on a non-send op");

endmodule

bind i2c_eeprom_transfer_sequencer_core i2cs_checker u_i2cs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_bus_op     (res.bus_op),
	.res_bus_byte   (res.bus_byte),
	.res_read_valid (res.read_valid),
	.res_want_data  (res.want_data),
	.res_status     (res.status),
	.res_last       (res.last)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import i2cs_pkg::*;

	localparam logic [2:0]           REQ_SPARE   = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;
	localparam int                   LIMIT_CYCLES = 400000;
	localparam int                   DRAIN_CYCLES = 12;
	localparam int                   N_SETTINGS   = 7;
	localparam int                   PER_SETTING  = 30;
	localparam res_t                 NO_RES       = '0;

	typedef struct packed {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] dat;
		item_t                it;
		logic [2:0]           n;
		res_t [3:0]           r;
	} row_t;

	logic clk;
	logic arst_n;

	i2cs_req_if req_ch();
	i2cs_res_if res_ch();
	i2cs_cfg_if cfg_ch();

	i2c_eeprom_transfer_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// sequencer mirror
	cfg_t        m_cfg;
	phase_t      ph;
	logic        wr;
	logic [15:0] caddr;
	logic [15:0] left;
	logic [15:0] pcnt;

	res_t new_prims[$];
	res_t primitives_due[$];
	row_t dir_rows[$];

	// hand-typed results for the next directed transaction
	bit         typed_on;
	logic [2:0] typed_n;
	res_t [3:0] typed_r;

	int  n_err, cycles, req_acc, acted, res_acc, cfg_acc, n_settings;
	int  n_ok, n_nack, n_tmo;
	bit  long_job, tx_calm, rx_calm;

	function automatic res_t rs(bus_op_t op, logic [7:0] b, logic [7:0] rd, logic rv,
			logic want, status_t st);
		res_t r;
		r.bus_op     = op;
		r.bus_byte   = b;
		r.read_data  = rd;
		r.read_valid = rv;
		r.want_data  = want;
		r.status     = st;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic void prim(bus_op_t op, logic [7:0] b);
		new_prims.push_back(rs(op, b, 8'h00, 1'b0, 1'b0, ST_BUSY));
	endfunction

	function automatic logic [7:0] ctl_byte_for(logic rw);
		logic [7:0] v;
		v = {m_cfg.dev_ctrl[7:1], rw};
		if (m_cfg.high_bits) begin
			v[3:1] = v[3:1] | caddr[10:8];
		end
		return v;
	endfunction

	function automatic void poll_dev();
		prim(OP_START, 8'h00);
		prim(OP_SEND, ctl_byte_for(1'b0));
		prim(OP_WAIT, 8'h00);
	endfunction

	function automatic void close_xfer(status_t st);
		new_prims.push_back(rs(OP_STOP, 8'h00, 8'h00, 1'b0, 1'b0, st));
		ph = PH_IDLE;
	endfunction

	function automatic void send_addr();
		if (m_cfg.two_addr) begin
			prim(OP_SEND, caddr[15:8]);
			ph = PH_ADDRH_ACK;
		end else begin
			prim(OP_SEND, caddr[7:0]);
			ph = PH_ADDRL_ACK;
		end
		prim(OP_WAIT, 8'h00);
	endfunction

	function automatic void poll_miss();
		logic [15:0] lim;
		lim = (m_cfg.poll_limit == 16'd0) ? 16'd1 : m_cfg.poll_limit;
		if (pcnt >= lim) begin
			close_xfer(ST_TIMEOUT);
		end else begin
			pcnt = pcnt + 16'd1;
			poll_dev();
		end
	endfunction

	// bus primitives caused by one request or response
	function automatic void next_primitives(item_t it);
		int unsigned pm;
		res_t        t;
		new_prims.delete();
		pm = (32'd1 << m_cfg.page_log2) - 32'd1;
		if (ph == PH_IDLE
				&& (it.req_type == REQ_BEGIN_READ || it.req_type == REQ_BEGIN_WRITE)) begin
			caddr = it.address;
			left  = it.count;
			wr    = (it.req_type == REQ_BEGIN_WRITE);
			if (!wr) begin
				poll_dev();
				ph = PH_CTRL_ACK;
			end else begin
				prim(OP_STOP, 8'h00);
				poll_dev();
				pcnt = 16'd1;
				ph = (left == 16'd0) ? PH_FINAL_POLL : PH_CTRL_ACK;
			end
		end else if (it.req_type == REQ_ACK) begin
			case (ph)
				PH_CTRL_ACK: begin
					if (it.nack) begin
						if (wr) poll_miss();
						else close_xfer(ST_NACK);
					end else begin
						send_addr();
					end
				end
				PH_ADDRH_ACK: begin
					if (it.nack) begin
						close_xfer(ST_NACK);
					end else begin
						prim(OP_SEND, caddr[7:0]);
						prim(OP_WAIT, 8'h00);
						ph = PH_ADDRL_ACK;
					end
				end
				PH_ADDRL_ACK: begin
					if (it.nack) begin
						close_xfer(ST_NACK);
					end else if (wr) begin
						new_prims.push_back(rs(OP_STATUS, 8'h00, 8'h00, 1'b0, 1'b1,
							ST_BUSY));
						ph = PH_WDATA_WAIT;
					end else begin
						prim(OP_START, 8'h00);
						prim(OP_SEND, ctl_byte_for(1'b1));
						prim(OP_WAIT, 8'h00);
						ph = PH_RCTRL_ACK;
					end
				end
				PH_RCTRL_ACK: begin
					if (it.nack) begin
						close_xfer(ST_NACK);
					end else if (left == 16'd0) begin
						close_xfer(ST_OK);
					end else begin
						prim((left == 16'd1) ? OP_RD_NACK : OP_RD_ACK, 8'h00);
						ph = PH_RDATA;
					end
				end
				PH_WDATA_ACK: begin
					if (it.nack) begin
						close_xfer(ST_NACK);
					end else begin
						caddr = caddr + 16'd1;
						left  = left - 16'd1;
						if (left == 16'd0 || ({16'd0, caddr} & pm) == 32'd0) begin
							prim(OP_STOP, 8'h00);
							poll_dev();
							pcnt = 16'd1;
							ph = (left == 16'd0) ? PH_FINAL_POLL : PH_CTRL_ACK;
						end else begin
							new_prims.push_back(rs(OP_STATUS, 8'h00, 8'h00, 1'b0, 1'b1,
								ST_BUSY));
							ph = PH_WDATA_WAIT;
						end
					end
				end
				PH_FINAL_POLL: begin
					if (it.nack) poll_miss();
					else close_xfer(ST_OK);
				end
				default: ;
			endcase
		end else if (it.req_type == REQ_READ_BYTE && ph == PH_RDATA) begin
			left = left - 16'd1;
			if (left == 16'd0) begin
				new_prims.push_back(rs(OP_STOP, 8'h00, it.bus_read_byte, 1'b1, 1'b0, ST_OK));
				ph = PH_IDLE;
			end else begin
				new_prims.push_back(rs((left == 16'd1) ? OP_RD_NACK : OP_RD_ACK, 8'h00,
					it.bus_read_byte, 1'b1, 1'b0, ST_BUSY));
			end
		end else if (it.req_type == REQ_WRITE_DATA && ph == PH_WDATA_WAIT) begin
			prim(OP_SEND, it.write_byte);
			prim(OP_WAIT, 8'h00);
			ph = PH_WDATA_ACK;
		end
		if (new_prims.size() > 0) begin
			t = new_prims.pop_back();
			t.last = 1'b1;
			new_prims.push_back(t);
		end
	endfunction

	function automatic void check_field(string f, int unsigned e, int unsigned a);
		if (e != a) begin
			n_err++;
			$display("%0t: %s expected %0h got %0h", $time, f, e, a);
		end
	endfunction

	always @(posedge clk) begin
		item_t rq;
		res_t  got;
		res_t  want;
		if (arst_n) begin
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("%0t: watchdog expired, %0d primitives outstanding", $time,
					primitives_due.size());
				$display("FAIL i2c_eeprom_transfer_sequencer_core");
				$finish;
			end else begin
				if (cfg_ch.valid && cfg_ch.ready) begin
					case (cfg_ch.index)
						CFG_DEVICE_CONTROL: m_cfg.dev_ctrl   = cfg_ch.data[7:0];
						CFG_TWO_ADDR:       m_cfg.two_addr   = cfg_ch.data[0];
						CFG_HIGH_BITS:      m_cfg.high_bits  = cfg_ch.data[0];
						CFG_PAGE_LOG2:      m_cfg.page_log2  = cfg_ch.data[3:0];
						CFG_POLL_LIMIT:     m_cfg.poll_limit = cfg_ch.data;
						default: ;
					endcase
					cfg_acc++;
				end
				if (req_ch.valid && req_ch.ready) begin
					rq.req_type      = req_ch.req_type;
					rq.address       = req_ch.address;
					rq.count         = req_ch.count;
					rq.write_byte    = req_ch.write_byte;
					rq.nack          = req_ch.nack;
					rq.bus_read_byte = req_ch.bus_read_byte;
					next_primitives(rq);
					if (new_prims.size() > 0) acted++;
					if (typed_on) begin
						for (int i = 0; i < int'(typed_n); i++)
							primitives_due.push_back(typed_r[i]);
						typed_on = 1'b0;
					end else begin
						foreach (new_prims[i]) primitives_due.push_back(new_prims[i]);
					end
					req_acc++;
				end
				if (res_ch.valid && res_ch.ready) begin
					got.bus_op     = bus_op_t'(res_ch.bus_op);
					got.bus_byte   = res_ch.bus_byte;
					got.read_data  = res_ch.read_data;
					got.read_valid = res_ch.read_valid;
					got.want_data  = res_ch.want_data;
					got.status     = status_t'(res_ch.status);
					got.last       = res_ch.last;
					if (primitives_due.size() == 0) begin
						n_err++;
						$display("%0t: primitive op %0d byte %0h with none outstanding", $time,
							got.bus_op, got.bus_byte);
					end else begin
						want = primitives_due.pop_front();
						check_field("bus_op", 32'(want.bus_op), 32'(got.bus_op));
						check_field("bus_byte", 32'(want.bus_byte), 32'(got.bus_byte));
						check_field("read_data", 32'(want.read_data), 32'(got.read_data));
						check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
						check_field("want_data", 32'(want.want_data), 32'(got.want_data));
						check_field("status", 32'(want.status), 32'(got.status));
						check_field("last", 32'(want.last), 32'(got.last));
					end
					if (got.bus_op == OP_STOP) begin
						case (got.status)
							ST_OK:      n_ok++;
							ST_NACK:    n_nack++;
							ST_TIMEOUT: n_tmo++;
							default: ;
						endcase
					end
					res_acc++;
				end
			end
		end
	end

	// stretches of back-to-back traffic between bursts of random waits
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic item_t itm(logic [2:0] t, logic [15:0] a, logic [15:0] c, logic [7:0] w,
			logic n, logic [7:0] rb);
		item_t it;
		it.req_type      = t;
		it.address       = a;
		it.count         = c;
		it.write_byte    = w;
		it.nack          = n;
		it.bus_read_byte = rb;
		return it;
	endfunction

	task automatic add_row(input item_t it, input int n, input res_t a, input res_t b,
			input res_t c, input res_t d);
		row_t w;
		case (n)
			1: a.last = 1'b1;
			2: b.last = 1'b1;
			3: c.last = 1'b1;
			4: d.last = 1'b1;
			default: ;
		endcase
		w = '0;
		w.it = it;
		w.n  = 3'(n);
		w.r  = {d, c, b, a};
		dir_rows.push_back(w);
	endtask

	task automatic add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] dat);
		row_t w;
		w = '0;
		w.is_cfg = 1'b1;
		w.idx    = idx;
		w.dat    = dat;
		dir_rows.push_back(w);
	endtask

	// next request, steered by the mirror so most transactions move a transfer on
	function automatic item_t pick_request();
		item_t it;
		int    r;
		it.req_type      = 3'($urandom_range(0, 7));
		it.address       = 16'($urandom);
		it.count         = 16'($urandom);
		it.write_byte    = 8'($urandom);
		it.nack          = 1'($urandom);
		it.bus_read_byte = 8'($urandom);
		if ($urandom_range(0, 99) >= 8) begin
			r = $urandom_range(0, 99);
			case (ph)
				PH_IDLE: begin
					it.req_type = $urandom_range(0, 1) ? REQ_BEGIN_WRITE : REQ_BEGIN_READ;
					if (r < 10) it.count = 16'd0;
					else if (r < 75) it.count = 16'($urandom_range(1, 6));
					else if (r < 95) it.count = 16'($urandom_range(7, 24));
				end
				PH_RDATA:      it.req_type = REQ_READ_BYTE;
				PH_WDATA_WAIT: it.req_type = REQ_WRITE_DATA;
				PH_CTRL_ACK: begin
					it.req_type = REQ_ACK;
					it.nack     = wr ? (r < 30) : (r < 4);
				end
				PH_FINAL_POLL: begin
					it.req_type = REQ_ACK;
					it.nack     = (r < 35);
				end
				default: begin
					// long transfers are cut short by a nack
					it.req_type = REQ_ACK;
					it.nack     = long_job || (r < 4);
				end
			endcase
		end
		if (ph == PH_IDLE
				&& (it.req_type == REQ_BEGIN_READ || it.req_type == REQ_BEGIN_WRITE)) begin
			long_job = (it.count > 16'd40);
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		int prev;
		req_ch.req_type      = it.req_type;
		req_ch.address       = it.address;
		req_ch.count         = it.count;
		req_ch.write_byte    = it.write_byte;
		req_ch.nack          = it.nack;
		req_ch.bus_read_byte = it.bus_read_byte;
		req_ch.valid         = 1'b1;
		prev = req_acc;
		do @(negedge clk); while (req_acc == prev);
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		req_ch.valid = 1'b0;
		while (primitives_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] dat);
		int prev;
		cfg_ch.index = idx;
		cfg_ch.data  = dat;
		cfg_ch.valid = 1'b1;
		prev = cfg_acc;
		do @(negedge clk); while (cfg_acc == prev);
		cfg_ch.valid = 1'b0;
	endtask

	initial begin
		int gap;
		int prev;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(rx_calm);
			if (gap > 0) begin
				res_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			prev = res_acc;
			do @(negedge clk); while (res_acc == prev);
		end
	end

	initial begin
		row_t w;
		int   target;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_BEGIN_READ;
		req_ch.address       = '0;
		req_ch.count         = '0;
		req_ch.write_byte    = '0;
		req_ch.nack          = 1'b0;
		req_ch.bus_read_byte = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = CFG_DEVICE_CONTROL;
		cfg_ch.data          = '0;
		m_cfg.dev_ctrl       = RST_DEVICE_CONTROL;
		m_cfg.two_addr       = RST_TWO_ADDR;
		m_cfg.high_bits      = RST_HIGH_BITS;
		m_cfg.page_log2      = RST_PAGE_LOG2;
		m_cfg.poll_limit     = RST_POLL_LIMIT;
		ph                   = PH_IDLE;
		wr                   = 1'b0;
		caddr                = '0;
		left                 = '0;
		pcnt                 = '0;
		n_settings           = 1;

		// out-of-phase transactions are dropped
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_SPARE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 8'hFF), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		// random read of two bytes, A8 lands in the control byte
		add_row(itm(REQ_BEGIN_READ, 16'h0123, 16'd2, 8'h00, 1'b0, 8'h00), 3,
			rs(OP_START, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_SEND, 8'hA2, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_WAIT, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY), NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_BEGIN_WRITE, 16'h0040, 16'd1, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_READ_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'hFF), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_READ_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 1,
			rs(OP_STOP, 8'h00, 8'h00, 1'b1, 1'b0, ST_OK), NO_RES, NO_RES, NO_RES);
		// zero-length read at the top address
		add_row(itm(REQ_BEGIN_READ, 16'hFFFF, 16'd0, 8'h00, 1'b0, 8'h00), 3,
			rs(OP_START, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_SEND, 8'hAE, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_WAIT, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY), NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 3,
			rs(OP_START, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_SEND, 8'hAF, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_WAIT, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY), NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 1,
			rs(OP_STOP, 8'h00, 8'h00, 1'b0, 1'b0, ST_OK), NO_RES, NO_RES, NO_RES);
		// two-byte write wrapping past the top address onto a new page
		add_row(itm(REQ_BEGIN_WRITE, 16'hFFFF, 16'd2, 8'h00, 1'b0, 8'h00), 4,
			rs(OP_STOP, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_START, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_SEND, 8'hAE, 8'h00, 1'b0, 1'b0, ST_BUSY),
			rs(OP_WAIT, 8'h00, 8'h00, 1'b0, 1'b0, ST_BUSY));
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b1, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 1,
			rs(OP_STATUS, 8'h00, 8'h00, 1'b0, 1'b1, ST_BUSY), NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_WRITE_DATA, 16'h0000, 16'h0000, 8'hFF, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_WRITE_DATA, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00), 1,
			rs(OP_STOP, 8'h00, 8'h00, 1'b0, 1'b0, ST_OK), NO_RES, NO_RES, NO_RES);
		// nack on the control byte of a read
		add_row(itm(REQ_BEGIN_READ, 16'h0000, 16'd5, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b1, 8'h00), 1,
			rs(OP_STOP, 8'h00, 8'h00, 1'b0, 1'b0, ST_NACK), NO_RES, NO_RES, NO_RES);
		// zero-length write running out of polls
		add_cfg_row(CFG_POLL_LIMIT, 16'd1);
		add_row(itm(REQ_BEGIN_WRITE, 16'h07FF, 16'd0, 8'h00, 1'b0, 8'h00), 0,
			NO_RES, NO_RES, NO_RES, NO_RES);
		add_row(itm(REQ_ACK, 16'h0000, 16'h0000, 8'h00, 1'b1, 8'h00), 1,
			rs(OP_STOP, 8'h00, 8'h00, 1'b0, 1'b0, ST_TIMEOUT), NO_RES, NO_RES, NO_RES);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			w = dir_rows[i];
			if (w.is_cfg) begin
				settle();
				write_reg(w.idx, w.dat);
				n_settings++;
			end else begin
				if (w.n > 0) begin
					typed_n  = w.n;
					typed_r  = w.r;
					typed_on = 1'b1;
				end
				send_item(w.it);
			end
		end

		for (int s = 0; s < N_SETTINGS; s++) begin
			settle();
			case (s)
				0: begin
					write_reg(CFG_DEVICE_CONTROL, 16'h0000);
					write_reg(CFG_TWO_ADDR, 16'h0000);
					write_reg(CFG_HIGH_BITS, 16'h0000);
					write_reg(CFG_PAGE_LOG2, 16'h0000);
					write_reg(CFG_POLL_LIMIT, 16'd1);
				end
				1: begin
					write_reg(CFG_DEVICE_CONTROL, 16'h00FF);
					write_reg(CFG_TWO_ADDR, 16'h0001);
					write_reg(CFG_HIGH_BITS, 16'h0001);
					write_reg(CFG_PAGE_LOG2, 16'd8);
					write_reg(CFG_POLL_LIMIT, 16'hFFFF);
				end
				2: begin
					write_reg(CFG_DEVICE_CONTROL, 16'($urandom));
					write_reg(CFG_TWO_ADDR, 16'h0001);
					write_reg(CFG_HIGH_BITS, 16'h0000);
					write_reg(CFG_PAGE_LOG2, 16'd15);
					// a zero limit behaves as a single poll
					write_reg(CFG_POLL_LIMIT, 16'd0);
					write_reg(CFG_SPARE, 16'($urandom));
				end
				default: begin
					// junk above the register width must be dropped
					write_reg(CFG_DEVICE_CONTROL, 16'($urandom));
					write_reg(CFG_TWO_ADDR, 16'($urandom));
					write_reg(CFG_HIGH_BITS, 16'($urandom));
					write_reg(CFG_PAGE_LOG2,
						16'(($urandom & 32'h0000_FFF0) | $urandom_range(0, 8)));
					write_reg(CFG_POLL_LIMIT, 16'($urandom_range(1, 4)));
				end
			endcase
			n_settings++;
			target = acted + PER_SETTING;
			while (acted < target || ph != PH_IDLE) send_item(pick_request());
		end

		settle();
		$display("%0d requests taken, %0d acted on, %0d bus primitives checked, %0d settings",
			req_acc, acted, res_acc, n_settings);
		$display("transfers closed: %0d ok, %0d on nack, %0d on poll timeout",
			n_ok, n_nack, n_tmo);
		if (n_err == 0) begin
			$display("PASS i2c_eeprom_transfer_sequencer_core");
		end else begin
			$display("FAIL i2c_eeprom_transfer_sequencer_core");
		end
		$finish;
	end

endmodule
